@@ src/lprc_pkg.sv @@
// Shared types and constants for the LRU page replacement core.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lprc_pkg;

    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 5;
    localparam int FAULT_W       = 32;
    localparam int OUTCOME_W     = 2;

    localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 5'd16;
    localparam logic [FAULT_W-1:0] FAULT_MAX       = 32'hFFFF_FFFF;

    localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_FILL    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_REPLACE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SELECT,
        ST_UPDATE,
        ST_TOUCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic select;
        logic update;
        logic touch;
    } lprc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic touch_done;
    } lprc_stat_t;

endpackage

`default_nettype wire

@@ src/lprc_ctrl.sv @@
// Sequencing state machine of the LRU page replacement core.
// Depends on lprc_pkg for the state type and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module lprc_ctrl
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  lprc_pkg::lprc_stat_t stat,
    output lprc_pkg::lprc_cmd_t  cmd,
    output logic                busy
);

    lprc_pkg::state_t state_reg;
    lprc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lprc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lprc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lprc_pkg::ST_SCAN;
                end
            end
            lprc_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = lprc_pkg::ST_SELECT;
                end
            end
            lprc_pkg::ST_SELECT:
            begin
                state_next = lprc_pkg::ST_UPDATE;
            end
            lprc_pkg::ST_UPDATE:
            begin
                state_next = lprc_pkg::ST_TOUCH;
            end
            lprc_pkg::ST_TOUCH:
            begin
                if (stat.touch_done)
                begin
                    state_next = lprc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lprc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            lprc_pkg::ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            lprc_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            lprc_pkg::ST_SELECT:
            begin
                cmd.select = 1'b1;
            end
            lprc_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            lprc_pkg::ST_TOUCH:
            begin
                cmd.touch = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/lprc_dp.sv @@
// Datapath of the LRU page replacement core: page memory, valid bits,
// recency order, fault counter and result registers. Depends on lprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lprc_dp
#(
    parameter int FRAMES    = lprc_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lprc_pkg::PAGE_BITS_DEF,
    localparam int FIDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  lprc_pkg::lprc_cmd_t              cmd,
    output lprc_pkg::lprc_stat_t             stat,
    input  wire                              cfg_write,
    input  wire  [lprc_pkg::CFG_W-1:0]       cfg_data,
    input  wire                              start_new,
    input  wire  [PAGE_BITS-1:0]             page_number,
    output logic                             done,
    output logic [lprc_pkg::OUTCOME_W-1:0]   outcome,
    output logic [FIDX_W-1:0]                frame_index,
    output logic [PAGE_BITS-1:0]             evicted_page,
    output logic [lprc_pkg::FAULT_W-1:0]     fault_total
);

    localparam int CNT_LOG = $clog2(FRAMES + 1);
    localparam int AW      = (CNT_LOG > lprc_pkg::CFG_W) ? CNT_LOG : lprc_pkg::CFG_W;

    logic [lprc_pkg::CFG_W-1:0]     frame_count_reg;
    logic [AW-1:0]                  fc_ext;
    logic [AW-1:0]                  active_cnt;

    logic [PAGE_BITS-1:0]           page_mem [FRAMES];
    logic [PAGE_BITS-1:0]           rd_data_reg;
    logic [FIDX_W-1:0]              rd_addr;
    logic                           mem_wr;

    logic [PAGE_BITS-1:0]           page_reg;
    logic [FIDX_W-1:0]              idx_reg;
    logic                           hit_reg;
    logic [FIDX_W-1:0]              hit_frame_reg;
    logic                           empty_reg;
    logic [FIDX_W-1:0]              empty_frame_reg;
    logic [FIDX_W-1:0]              victim_reg;
    logic [FIDX_W-1:0]              frame_sel_reg;
    logic [lprc_pkg::OUTCOME_W-1:0] outcome_sel_reg;
    logic [FIDX_W-1:0]              carry_reg;
    logic [FRAMES-1:0]              valid_reg;
    logic [FIDX_W-1:0]              order_reg [FRAMES];
    logic [lprc_pkg::FAULT_W-1:0]   fault_reg;

    logic                           done_reg;
    logic [lprc_pkg::OUTCOME_W-1:0] outcome_reg;
    logic [FIDX_W-1:0]              frame_index_reg;
    logic [PAGE_BITS-1:0]           evicted_reg;

    logic                           frame_active;
    logic [FIDX_W-1:0]              order_cur;
    logic                           hit_now;
    logic                           empty_now;
    logic [FIDX_W-1:0]              frame_choice;
    logic [lprc_pkg::OUTCOME_W-1:0] outcome_choice;

    // Clamp the register to 1..FRAMES
    assign fc_ext = AW'(frame_count_reg);
    always_comb
    begin
        if (frame_count_reg == '0)
        begin
            active_cnt = AW'(1);
        end
        else if (fc_ext > AW'(FRAMES))
        begin
            active_cnt = AW'(FRAMES);
        end
        else
        begin
            active_cnt = fc_ext;
        end
    end

    assign frame_active = AW'(idx_reg) < active_cnt;
    assign order_cur    = order_reg[idx_reg];
    assign hit_now      = valid_reg[idx_reg] && frame_active && (rd_data_reg == page_reg);
    assign empty_now    = !valid_reg[idx_reg] && frame_active;

    always_comb
    begin
        if (hit_reg)
        begin
            frame_choice   = hit_frame_reg;
            outcome_choice = lprc_pkg::OUT_HIT;
        end
        else if (empty_reg)
        begin
            frame_choice   = empty_frame_reg;
            outcome_choice = lprc_pkg::OUT_FILL;
        end
        else
        begin
            frame_choice   = victim_reg;
            outcome_choice = lprc_pkg::OUT_REPLACE;
        end
    end

    // Read one frame ahead of the compare during the scan
    always_comb
    begin
        if (cmd.scan)
        begin
            rd_addr = FIDX_W'(idx_reg + 1'b1);
        end
        else if (cmd.select)
        begin
            rd_addr = frame_choice;
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign mem_wr = cmd.update && (outcome_sel_reg != lprc_pkg::OUT_HIT);

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            page_mem[frame_sel_reg] <= page_reg;
        end
        rd_data_reg <= page_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= lprc_pkg::FRAME_COUNT_RST;
        end
        else if (cfg_write)
        begin
            frame_count_reg <= cfg_data;
        end
    end

    // Control state: valid bits, recency order, fault counter, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fault_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                order_reg[i] <= FIDX_W'(i);
            end
        end
        else
        begin
            done_reg <= cmd.update;
            if (cmd.accept && start_new)
            begin
                valid_reg <= '0;
                fault_reg <= '0;
                for (int i = 0; i < FRAMES; i++)
                begin
                    order_reg[i] <= FIDX_W'(i);
                end
            end
            if (cmd.update)
            begin
                valid_reg[frame_sel_reg] <= 1'b1;
                if ((outcome_sel_reg != lprc_pkg::OUT_HIT) && (fault_reg != lprc_pkg::FAULT_MAX))
                begin
                    fault_reg <= fault_reg + 1'b1;
                end
            end
            // Insert the used frame at the front, pushing entries back until it is found
            if (cmd.touch)
            begin
                order_reg[idx_reg] <= carry_reg;
            end
        end
    end

    // Payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            page_reg  <= page_number;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        if (cmd.scan)
        begin
            idx_reg <= FIDX_W'(idx_reg + 1'b1);
            if (hit_now && !hit_reg)
            begin
                hit_reg       <= 1'b1;
                hit_frame_reg <= idx_reg;
            end
            if (empty_now && !empty_reg)
            begin
                empty_reg       <= 1'b1;
                empty_frame_reg <= idx_reg;
            end
            // Deepest active entry in the order wins
            if (AW'(order_cur) < active_cnt)
            begin
                victim_reg <= order_cur;
            end
        end
        if (cmd.select)
        begin
            frame_sel_reg   <= frame_choice;
            outcome_sel_reg <= outcome_choice;
        end
        if (cmd.update)
        begin
            outcome_reg     <= outcome_sel_reg;
            frame_index_reg <= frame_sel_reg;
            evicted_reg     <= (outcome_sel_reg == lprc_pkg::OUT_REPLACE) ? rd_data_reg : '0;
            carry_reg       <= frame_sel_reg;
            idx_reg         <= '0;
        end
        if (cmd.touch)
        begin
            carry_reg <= order_cur;
            idx_reg   <= FIDX_W'(idx_reg + 1'b1);
        end
    end

    assign stat.scan_last  = (idx_reg == FIDX_W'(FRAMES - 1));
    assign stat.touch_done = (order_cur == frame_sel_reg);

    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign frame_index  = frame_index_reg;
    assign evicted_page = evicted_reg;
    assign fault_total  = fault_reg;

`ifndef SYNTH
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (outcome != lprc_pkg::OUT_REPLACE) |-> (evicted_page == '0))
        else $error("evicted page nonzero without a replacement");

    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (outcome == lprc_pkg::OUT_HIT) || (outcome == lprc_pkg::OUT_FILL)
                 || (outcome == lprc_pkg::OUT_REPLACE))
        else $error("undefined outcome code");

    a_frame_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> valid_reg[frame_sel_reg])
        else $error("used frame not marked valid");

    a_fault_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && (outcome_sel_reg != lprc_pkg::OUT_HIT) |=> (fault_reg != '0))
        else $error("fault not counted");
`endif

endmodule

`default_nettype wire

@@ src/lru_page_replacement_core.sv @@
// Top level of the LRU page replacement core.
// Instantiates lprc_ctrl and lprc_dp; depends on lprc_pkg.
//
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------------
//  request   | start_new, page_number                    | start high while busy low
//  result    | outcome, frame_index, evicted_page,       | done, one cycle, no stall
//            | fault_total                               |
//  config    | cfg_data                                  | cfg_valid and cfg_ready
//
// One transaction runs from accept back to ready through a scan of all frames through
// the single read port of the page memory, one read of the chosen frame, one update,
// and a front insertion that walks the order one entry per cycle.
// The result strobe done is registered from the update command, which follows the select
// state after the scan ends; the receiver cannot stall.
// Reset clears the valid bits, restores the identity recency order and zeroes the fault count.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_replacement_core
#(
    parameter int FRAMES    = lprc_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lprc_pkg::PAGE_BITS_DEF,
    localparam int FIDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire                              start_new,
    input  wire  [PAGE_BITS-1:0]             page_number,
    output logic                             done,
    output logic [lprc_pkg::OUTCOME_W-1:0]   outcome,
    output logic [FIDX_W-1:0]                frame_index,
    output logic [PAGE_BITS-1:0]             evicted_page,
    output logic [lprc_pkg::FAULT_W-1:0]     fault_total,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [lprc_pkg::CFG_W-1:0]       cfg_data
);

    lprc_pkg::lprc_cmd_t  cmd;
    lprc_pkg::lprc_stat_t stat;

    // The register is always writable
    assign cfg_ready = 1'b1;

    lprc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    lprc_dp
    #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .start_new    (start_new),
        .page_number  (page_number),
        .done         (done),
        .outcome      (outcome),
        .frame_index  (frame_index),
        .evicted_page (evicted_page),
        .fault_total  (fault_total)
    );

endmodule

`default_nettype wire
